// ===== hdl/plfd_pkg.sv =====
// ----------------------------------------------------------------------------
// plfd_pkg
// Shared constants and types for the pose interpolation block.
// ----------------------------------------------------------------------------
package plfd_pkg;

    localparam int AXES_DEF       = 6;
    localparam int COORD_BITS_DEF = 32;
    localparam int TIME_BITS      = 48;
    localparam int RATIO_BITS     = 17;
    localparam int MIN_DT_BITS    = 20;
    localparam int AXIS_BITS      = 3;
    localparam int MODE_BITS      = 2;
    localparam logic [MIN_DT_BITS-1:0] MIN_DT_RESET = 20'd1000;
    localparam logic [29:0] NS_PER_S = 30'd1000000000;

    localparam logic [MODE_BITS-1:0] MODE_LOAD  = 2'd0;
    localparam logic [MODE_BITS-1:0] MODE_FIRST = 2'd1;
    localparam logic [MODE_BITS-1:0] MODE_LATER = 2'd2;

    // commands from controller to datapath
    typedef struct packed {
        logic load;       // capture input item fields
        logic pos_calc;   // compute position of current axis
        logic div_start;  // start divider on velocity
        logic acc_start;  // start divider on acceleration
        logic commit;     // write previous pose and velocity of axis
        logic out_load;   // place result in output register
        logic next_axis;  // advance axis counter
        logic finish;     // store sample time as previous
    } plfd_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic div_done;
        logic is_last;
        logic skip;
    } plfd_sts_t;

endpackage

// ===== hdl/plfd_div.sv =====
// ----------------------------------------------------------------------------
// plfd_div
// Sequential rate divider: |diff| * 1e9 / dt, rounded, signed and saturated.
// ----------------------------------------------------------------------------
module plfd_div #(
    parameter int CB = plfd_pkg::COORD_BITS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           start,
    input  logic signed [CB:0]             diff,
    input  logic [plfd_pkg::TIME_BITS-1:0] dt,
    output logic                           done,
    output logic signed [CB-1:0]           quot
);
    localparam int MW  = CB + 1;
    localparam int NW  = MW + 30;
    localparam int CW  = $clog2(NW + 1);
    localparam int RW  = plfd_pkg::TIME_BITS + 1;

    logic [NW-1:0]  num_reg, num_next;
    logic [NW-1:0]  q_reg, q_next;
    logic [RW-1:0]  rem_reg, rem_next;
    logic [CW-1:0]  cnt_reg, cnt_next;
    logic           busy_reg, busy_next;
    logic           neg_reg, neg_next;
    logic           done_reg, done_next;
    logic signed [CB-1:0] quot_reg, quot_next;
    logic [MW-1:0]  mag;
    logic [RW-1:0]  shifted;
    logic [RW-1:0]  dtx;
    logic [NW:0]    qr;
    logic [RW:0]    rem2;
    logic           sat;

    assign mag  = diff[CB] ? MW'(-diff) : MW'(diff);
    assign dtx  = {1'b0, dt};
    assign shifted = {rem_reg[RW-2:0], num_reg[NW-1]};

    // one quotient bit per cycle, then round and saturate
    always_comb begin
        num_next  = num_reg;
        q_next    = q_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        neg_next  = neg_reg;
        done_next = 1'b0;
        quot_next = quot_reg;
        qr        = '0;
        rem2      = '0;
        sat       = 1'b0;
        if (start) begin
            num_next  = NW'(mag) * NW'(plfd_pkg::NS_PER_S);
            q_next    = '0;
            rem_next  = '0;
            cnt_next  = CW'(NW);
            busy_next = 1'b1;
            neg_next  = diff[CB];
        end else if (busy_reg) begin
            if (cnt_reg != '0) begin
                num_next = {num_reg[NW-2:0], 1'b0};
                if (shifted >= dtx) begin
                    rem_next = shifted - dtx;
                    q_next   = {q_reg[NW-2:0], 1'b1};
                end else begin
                    rem_next = shifted;
                    q_next   = {q_reg[NW-2:0], 1'b0};
                end
                cnt_next = cnt_reg - 1'b1;
            end else begin
                rem2 = {rem_reg, 1'b0};
                qr   = {1'b0, q_reg} + ((rem2 >= {1'b0, dtx}) ? (NW+1)'(1) : '0);
                sat  = (q_reg >= (NW'(1) << (CB-1)));
                if (neg_reg) begin
                    if (sat || qr >= ((NW+1)'(1) << (CB-1)))
                        quot_next = {1'b1, {(CB-1){1'b0}}};
                    else
                        quot_next = CB'(-qr);
                end else begin
                    if (sat || qr >= ((NW+1)'(1) << (CB-1)) - 1)
                        quot_next = {1'b0, {(CB-1){1'b1}}};
                    else
                        quot_next = CB'(qr);
                end
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        num_reg  <= num_next;
        q_reg    <= q_next;
        rem_reg  <= rem_next;
        cnt_reg  <= cnt_next;
        neg_reg  <= neg_next;
        quot_reg <= quot_next;
    end

    assign done = done_reg;
    assign quot = quot_reg;
endmodule

// ===== hdl/plfd_datapath.sv =====
// ----------------------------------------------------------------------------
// plfd_datapath
// Pose storage, interpolation, derivative sequencing and output register.
// ----------------------------------------------------------------------------
module plfd_datapath #(
    parameter int AXES = plfd_pkg::AXES_DEF,
    parameter int CB   = plfd_pkg::COORD_BITS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic [plfd_pkg::MIN_DT_BITS-1:0] min_dt,
    input  logic [plfd_pkg::MODE_BITS-1:0]  in_mode,
    input  logic [plfd_pkg::TIME_BITS-1:0]  in_time,
    input  logic [plfd_pkg::RATIO_BITS-1:0] in_ratio,
    input  logic                            in_sel,
    input  logic [plfd_pkg::AXIS_BITS-1:0]  in_axis,
    input  logic [CB-1:0]                   in_coord,
    input  plfd_pkg::plfd_cmd_t             cmd,
    output plfd_pkg::plfd_sts_t             sts,
    output logic [plfd_pkg::TIME_BITS-1:0]  o_time,
    output logic [plfd_pkg::AXIS_BITS-1:0]  o_axis,
    output logic [CB-1:0]                   o_pos,
    output logic [CB-1:0]                   o_vel,
    output logic [CB-1:0]                   o_acc,
    output logic                            o_last
);
    localparam int TB = plfd_pkg::TIME_BITS;
    localparam int AB = plfd_pkg::AXIS_BITS;
    localparam int PW = CB + 18;
    localparam logic signed [CB+1:0] POS_HI = {3'b000, {(CB-1){1'b1}}};
    localparam logic signed [CB+1:0] POS_LO = {3'b111, {(CB-1){1'b0}}};

    logic signed [CB-1:0] start_reg [AXES];
    logic signed [CB-1:0] goal_reg  [AXES];
    logic signed [CB-1:0] ppos_reg  [AXES];
    logic signed [CB-1:0] pvel_reg  [AXES];
    logic [TB-1:0]        ptime_reg;
    logic                 have_reg;
    logic [TB-1:0]        time_reg;
    logic [plfd_pkg::RATIO_BITS-1:0] ratio_reg;
    logic                 skip_reg;
    logic [TB-1:0]        dt_reg;
    logic [AB-1:0]        ax_reg;
    logic signed [CB-1:0] pos_reg, vel_reg;
    logic [TB-1:0]        ot_reg;
    logic [AB-1:0]        oax_reg;
    logic [CB-1:0]        opos_reg, ovel_reg, oacc_reg;
    logic                 olast_reg;

    logic signed [CB:0]   span;
    logic [CB:0]          smag;
    logic [PW-1:0]        prod;
    logic [PW-17:0]       q;
    logic signed [CB+1:0] psum;
    logic signed [CB-1:0] pos_sat;
    logic                 skip_c;
    logic [TB:0]          dt_c;
    logic signed [CB:0]   ddiff;
    logic                 dstart;
    logic                 ddone;
    logic signed [CB-1:0] dq;

    // interpolation of current axis
    always_comb begin
        span = (CB+1)'(goal_reg[ax_reg]) - (CB+1)'(start_reg[ax_reg]);
        smag = span[CB] ? (CB+1)'(-span) : (CB+1)'(span);
        prod = PW'(smag) * PW'(ratio_reg) + PW'(32768);
        q    = prod[PW-1:16];
        psum = span[CB] ? (CB+2)'(start_reg[ax_reg]) - (CB+2)'(q)
                        : (CB+2)'(start_reg[ax_reg]) + (CB+2)'(q);
        if (psum > POS_HI)
            pos_sat = POS_HI[CB-1:0];
        else if (psum < POS_LO)
            pos_sat = POS_LO[CB-1:0];
        else
            pos_sat = psum[CB-1:0];
    end

    // skip decision for a sample item
    always_comb begin
        dt_c   = {1'b0, in_time} - {1'b0, ptime_reg};
        skip_c = (in_mode == plfd_pkg::MODE_FIRST) || !have_reg || dt_c[TB] ||
                 (dt_c[TB-1:0] == '0) ||
                 (dt_c[TB-1:0] < TB'(min_dt));
    end

    // acceleration uses the velocity just out of the divider
    assign dstart = cmd.div_start || cmd.acc_start;
    assign ddiff  = cmd.acc_start ? (CB+1)'(dq) - (CB+1)'(pvel_reg[ax_reg])
                                  : (CB+1)'(pos_reg) - (CB+1)'(ppos_reg[ax_reg]);

    plfd_div #(.CB(CB)) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (dstart),
        .diff    (ddiff),
        .dt      (dt_reg),
        .done    (ddone),
        .quot    (dq)
    );

    // state and registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < AXES; i++) begin
                start_reg[i] <= '0;
                goal_reg[i]  <= '0;
                ppos_reg[i]  <= '0;
                pvel_reg[i]  <= '0;
            end
            ptime_reg <= '0;
            have_reg  <= 1'b0;
            ax_reg    <= '0;
        end else begin
            if (cmd.load) begin
                ax_reg <= '0;
                if (in_mode == plfd_pkg::MODE_LOAD) begin
                    if (int'(in_axis) < AXES) begin
                        if (in_sel) goal_reg[in_axis[AB-1:0]]  <= in_coord;
                        else        start_reg[in_axis[AB-1:0]] <= in_coord;
                    end
                end
            end
            if (cmd.commit) begin
                ppos_reg[ax_reg] <= pos_reg;
                pvel_reg[ax_reg] <= skip_reg ? '0 : vel_reg;
            end
            if (cmd.next_axis) ax_reg <= ax_reg + 1'b1;
            if (cmd.finish) begin
                ptime_reg <= time_reg;
                have_reg  <= 1'b1;
            end
        end
        if (cmd.load) begin
            time_reg  <= in_time;
            ratio_reg <= in_ratio;
            skip_reg  <= skip_c;
            dt_reg    <= dt_c[TB-1:0];
        end
        if (cmd.pos_calc) begin
            pos_reg <= pos_sat;
            vel_reg <= '0;
        end
        // keep velocity when its divide ends and the acceleration divide starts
        if (cmd.acc_start) vel_reg <= dq;
        if (cmd.out_load) begin
            ot_reg    <= time_reg;
            oax_reg   <= ax_reg;
            opos_reg  <= pos_reg;
            ovel_reg  <= skip_reg ? '0 : vel_reg;
            oacc_reg  <= skip_reg ? '0 : dq;
            olast_reg <= (int'(ax_reg) == AXES - 1);
        end
    end

    assign sts.div_done = ddone;
    assign sts.is_last  = (int'(ax_reg) == AXES - 1);
    assign sts.skip     = skip_reg;
    assign o_time = ot_reg;
    assign o_axis = oax_reg;
    assign o_pos  = opos_reg;
    assign o_vel  = ovel_reg;
    assign o_acc  = oacc_reg;
    assign o_last = olast_reg;
endmodule

// ===== hdl/plfd_ctrl.sv =====
// ----------------------------------------------------------------------------
// plfd_ctrl
// Sequencer: accepts an item, walks the axes and hands results out.
// ----------------------------------------------------------------------------
module plfd_ctrl (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [plfd_pkg::MODE_BITS-1:0] in_mode,
    output logic                           out_valid,
    input  logic                           out_ready,
    input  plfd_pkg::plfd_sts_t            sts,
    output plfd_pkg::plfd_cmd_t            cmd
);
    typedef enum logic [2:0] {
        S_IDLE, S_POS, S_VEL, S_ACC, S_OUT, S_HOLD
    } state_t;

    state_t state_reg, state_next;
    logic   ov_reg, ov_next;
    logic   accept;

    assign in_ready  = (state_reg == S_IDLE);
    assign accept    = in_valid && in_ready;
    assign out_valid = ov_reg;

    always_comb begin
        state_next = state_reg;
        ov_next    = ov_reg && !out_ready;
        cmd        = '0;
        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    cmd.load = 1'b1;
                    if (in_mode inside {plfd_pkg::MODE_FIRST, plfd_pkg::MODE_LATER})
                        state_next = S_POS;
                end
            end
            S_POS: begin
                cmd.pos_calc = 1'b1;
                state_next   = S_VEL;
            end
            S_VEL: begin
                if (sts.skip) begin
                    state_next = S_OUT;
                end else begin
                    cmd.div_start = 1'b1;
                    state_next    = S_ACC;
                end
            end
            S_ACC: begin
                if (sts.div_done) begin
                    cmd.acc_start = 1'b1;
                    state_next    = S_HOLD;
                end
            end
            S_HOLD: begin
                if (sts.div_done) state_next = S_OUT;
            end
            S_OUT: begin
                if (!ov_reg || out_ready) begin
                    cmd.out_load = 1'b1;
                    cmd.commit   = 1'b1;
                    ov_next      = 1'b1;
                    if (sts.is_last) begin
                        cmd.finish = 1'b1;
                        state_next = S_IDLE;
                    end else begin
                        cmd.next_axis = 1'b1;
                        state_next    = S_POS;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            ov_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
        end
    end
endmodule

// ===== hdl/pose_lerp_finite_difference.sv =====
// ----------------------------------------------------------------------------
// pose_lerp_finite_difference
// Straight-line pose interpolation with finite-difference derivatives.
// ----------------------------------------------------------------------------
// Load items (mode 0) and ignored items (mode 3) need only their accept. A sample
// item is accepted and then yields AXES results; each axis walks the states
// POS, VEL, ACC, HOLD and OUT and uses the shared bit-serial divider twice
// per axis (velocity, then acceleration), or only POS, VEL and OUT when the
// step is skipped. A stalled result register adds its stall to the axis that
// waits on it. One item is processed at a time; a result may wait in the
// output register while the next axis is computed.
module pose_lerp_finite_difference #(
    parameter int AXES       = plfd_pkg::AXES_DEF,
    parameter int COORD_BITS = plfd_pkg::COORD_BITS_DEF
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          cfg_we,
    input  logic [19:0]   cfg_wdata,
    input  logic          s_tvalid,
    output logic          s_tready,
    // sample_time_ns, ratio, axis_index, coord_value
    input  logic [103:0]  s_tdata,
    // mode, endpoint_sel
    input  logic [2:0]    s_tuser,
    output logic          m_tvalid,
    input  logic          m_tready,
    // out_time_ns, out_axis, position, velocity, acceleration
    output logic [((plfd_pkg::TIME_BITS + plfd_pkg::AXIS_BITS + 3 * COORD_BITS + 7)
                   / 8) * 8 - 1:0] m_tdata,
    // last_axis
    output logic          m_tlast
);
    localparam int CB    = COORD_BITS;
    localparam int OUT_W = $bits(m_tdata);

    logic [plfd_pkg::MIN_DT_BITS-1:0] min_dt_reg;
    plfd_pkg::plfd_cmd_t cmd;
    plfd_pkg::plfd_sts_t sts;
    logic [47:0]   o_time;
    logic [2:0]    o_axis;
    logic [CB-1:0] o_pos, o_vel, o_acc;

    // configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_dt_reg <= plfd_pkg::MIN_DT_RESET;
        end else if (cfg_we) begin
            min_dt_reg <= cfg_wdata;
        end
    end

    plfd_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_mode   (s_tuser[1:0]),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .sts       (sts),
        .cmd       (cmd)
    );

    plfd_datapath #(.AXES(AXES), .CB(CB)) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .min_dt   (min_dt_reg),
        .in_mode  (s_tuser[1:0]),
        .in_time  (s_tdata[47:0]),
        .in_ratio (s_tdata[64:48]),
        .in_sel   (s_tuser[2]),
        .in_axis  (s_tdata[67:65]),
        .in_coord (CB'(s_tdata[99:68])),
        .cmd      (cmd),
        .sts      (sts),
        .o_time   (o_time),
        .o_axis   (o_axis),
        .o_pos    (o_pos),
        .o_vel    (o_vel),
        .o_acc    (o_acc),
        .o_last   (m_tlast)
    );

    assign m_tdata = OUT_W'({o_acc, o_vel, o_pos, o_axis, o_time});
endmodule

// ===== verif/pose_lerp_finite_difference_tb.sv =====
// ----------------------------------------------------------------------------
// pose_lerp_finite_difference_tb
// Drives load and sample items into the pose interpolation block and checks
// every axis result against a local predictor. Covers position extrapolation,
// derivative saturation and skipped steps, under varied min_dt settings and
// random idling on both streams.
// ----------------------------------------------------------------------------
module pose_lerp_finite_difference_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [plfd_pkg::MODE_BITS-1:0] MODE_NONE = 2'd3;
    localparam int  NUM_AXES  = plfd_pkg::AXES_DEF;
    localparam longint POS_MAX = 64'sd2147483647;
    localparam longint POS_MIN = -64'sd2147483648;
    localparam int  CYCLE_LIMIT = 4000000;

    typedef struct {
        logic [1:0]  mode;
        logic [47:0] t_ns;
        logic [16:0] ratio;
        logic        sel;
        logic [2:0]  axis;
        logic [31:0] coord;
    } pose_item_t;

    typedef struct {
        logic [47:0] t_ns;
        logic [2:0]  axis;
        logic [31:0] pos;
        logic [31:0] vel;
        logic [31:0] acc;
        logic        last;
    } axis_result_t;

    // predictor of the interpolator plus queue of pending axis results
    class pose_scoreboard;
        longint       start_p[NUM_AXES];
        longint       goal_p[NUM_AXES];
        longint       last_pos[NUM_AXES];
        longint       last_vel[NUM_AXES];
        logic [47:0]  last_t;
        bit           primed;
        logic [19:0]  min_dt;
        axis_result_t pending[$];
        int           errors;
        int           results_seen;
        int           samples_seen;
        int           skipped_seen;

        function void clear();
            for (int i = 0; i < NUM_AXES; i++) begin
                start_p[i] = 0; goal_p[i] = 0; last_pos[i] = 0; last_vel[i] = 0;
            end
            last_t = '0;
            primed = 0;
            min_dt = plfd_pkg::MIN_DT_RESET;
        endfunction

        function longint clamp_mag(logic [127:0] q, bit neg);
            if (neg)
                return (q >= 128'h8000_0000) ? POS_MIN : -longint'(q[63:0]);
            return (q >= 128'h7FFF_FFFF) ? POS_MAX : longint'(q[63:0]);
        endfunction

        // diff per second with round half away from zero
        function longint per_second(longint diff, logic [47:0] dt);
            logic [127:0] prod;
            logic [127:0] quo;
            logic [127:0] rem;
            logic [63:0]  mag;
            mag  = (diff < 0) ? -diff : diff;
            prod = {64'd0, mag} * 128'd1000000000;
            quo  = prod / {80'd0, dt};
            rem  = prod % {80'd0, dt};
            if (quo >= 128'h8000_0000)
                return clamp_mag(128'h8000_0000, diff < 0);
            if (2 * rem >= {80'd0, dt})
                quo++;
            return clamp_mag(quo, diff < 0);
        endfunction

        function longint lerp(longint s, longint g, logic [16:0] ratio);
            longint diff;
            logic [63:0] mag;
            logic [63:0] q;
            longint p;
            diff = g - s;
            mag  = (diff < 0) ? -diff : diff;
            q    = mag * ratio[16] + ((mag * ratio[15:0] + 64'd32768) >> 16);
            p    = (diff < 0) ? s - longint'(q) : s + longint'(q);
            if (p > POS_MAX) return POS_MAX;
            if (p < POS_MIN) return POS_MIN;
            return p;
        endfunction

        function void note_item(pose_item_t it);
            bit skip;
            logic [47:0] dt;
            longint pos;
            longint vel;
            longint acc;
            axis_result_t r;
            if (it.mode == plfd_pkg::MODE_LOAD) begin
                if (it.axis < NUM_AXES) begin
                    if (it.sel) goal_p[it.axis] = longint'(signed'(it.coord));
                    else        start_p[it.axis] = longint'(signed'(it.coord));
                end
                return;
            end
            if (it.mode == MODE_NONE)
                return;
            skip = (it.mode == plfd_pkg::MODE_FIRST) || !primed || (it.t_ns < last_t);
            dt = it.t_ns - last_t;
            if (!skip && (dt == 0 || dt < {28'd0, min_dt}))
                skip = 1;
            samples_seen++;
            if (skip) skipped_seen++;
            for (int i = 0; i < NUM_AXES; i++) begin
                pos = lerp(start_p[i], goal_p[i], it.ratio);
                vel = 0;
                acc = 0;
                if (!skip) begin
                    vel = per_second(pos - last_pos[i], dt);
                    acc = per_second(vel - last_vel[i], dt);
                end
                last_pos[i] = pos;
                last_vel[i] = vel;
                r.t_ns = it.t_ns;
                r.axis = 3'(i);
                r.pos  = pos[31:0];
                r.vel  = vel[31:0];
                r.acc  = acc[31:0];
                r.last = (i == NUM_AXES - 1);
                pending.push_back(r);
            end
            last_t = it.t_ns;
            primed = 1;
        endfunction

        function void check_result(axis_result_t got);
            axis_result_t exp_r;
            results_seen++;
            if (pending.size() == 0) begin
                $error("unexpected result: axis %0d time %0d", got.axis, got.t_ns);
                errors++;
                return;
            end
            exp_r = pending.pop_front();
            if (got.t_ns !== exp_r.t_ns) begin
                $error("out_time_ns: expected %0d actual %0d", exp_r.t_ns, got.t_ns);
                errors++;
            end
            if (got.axis !== exp_r.axis) begin
                $error("out_axis: expected %0d actual %0d", exp_r.axis, got.axis);
                errors++;
            end
            if (got.pos !== exp_r.pos) begin
                $error("position: expected %0d actual %0d",
                       signed'(exp_r.pos), signed'(got.pos));
                errors++;
            end
            if (got.vel !== exp_r.vel) begin
                $error("velocity: expected %0d actual %0d",
                       signed'(exp_r.vel), signed'(got.vel));
                errors++;
            end
            if (got.acc !== exp_r.acc) begin
                $error("acceleration: expected %0d actual %0d",
                       signed'(exp_r.acc), signed'(got.acc));
                errors++;
            end
            if (got.last !== exp_r.last) begin
                $error("last_axis: expected %0d actual %0d", exp_r.last, got.last);
                errors++;
            end
        endfunction
    endclass

    logic         aclk;
    logic         aresetn;
    logic         cfg_we;
    logic [19:0]  cfg_wdata;
    logic         s_tvalid;
    logic         s_tready;
    logic [103:0] s_tdata;
    logic [2:0]   s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [151:0] m_tdata;
    logic         m_tlast;

    pose_scoreboard sb;
    int           send_idle_pct;
    int           recv_stall_pct;
    logic [47:0]  now_ns;
    int           items_sent;
    int           cycles;

    pose_lerp_finite_difference dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    // clock
    initial begin
        aclk = 0;
        forever #6 aclk = ~aclk;
    end

    // watchdog
    initial cycles = 0;
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // result side: check accepted items, then pick next ready
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready)
                sb.check_result('{m_tdata[47:0], m_tdata[50:48], m_tdata[82:51],
                                  m_tdata[114:83], m_tdata[146:115], m_tlast});
            m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    task automatic send_item(pose_item_t it);
        if ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_tvalid <= 1;
        s_tdata  <= {4'b0, it.coord, it.axis, it.ratio, it.t_ns};
        s_tuser  <= {it.sel, it.mode};
        do @(posedge aclk); while (!s_tready);
        sb.note_item(it);
        items_sent++;
    endtask

    task automatic send_load(bit sel, logic [2:0] axis, logic [31:0] coord);
        send_item('{plfd_pkg::MODE_LOAD, 48'($urandom()), 17'($urandom()), sel, axis,
                    coord});
    endtask

    task automatic send_sample(logic [1:0] mode, logic [47:0] t, logic [16:0] ratio);
        send_item('{mode, t, ratio, 1'($urandom()), 3'($urandom()), $urandom()});
    endtask

    // drain, then let a trailing load settle before touching the register
    task automatic wait_idle();
        s_tvalid <= 0;
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic write_min_dt(logic [19:0] v);
        cfg_we    <= 1;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_we    <= 0;
        sb.min_dt = v;
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 3))
            0: return $urandom();
            1: return 32'($signed($urandom_range(0, 2000)) - 1000);
            2: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: return 32'($signed($urandom_range(0, 1 << 22)) - (1 << 21));
        endcase
    endfunction

    function automatic logic [16:0] rand_ratio();
        if ($urandom_range(0, 9) == 0) return 17'($urandom_range(65537, 131071));
        return 17'($urandom_range(0, 65536));
    endfunction

    // step size around the current threshold, with some bad steps
    function automatic logic [47:0] rand_step();
        logic [47:0] md;
        md = {28'd0, sb.min_dt};
        case ($urandom_range(0, 9))
            0: return 0;
            1: return (md > 0) ? md - $urandom_range(1, 3) : 48'd0;
            2: return md;
            3: return 48'($urandom()) << $urandom_range(0, 15);
            default: return md + $urandom_range(1, 2000000);
        endcase
    endfunction

    // one trajectory: load endpoints, first sample, then later samples
    task automatic run_trajectory();
        int n;
        n = $urandom_range(1, 6);
        for (int i = 0; i < n; i++)
            send_load(1'($urandom()),
                      (($urandom_range(0, 15) == 0) ? 3'd7 : 3'($urandom_range(0, 5))),
                      rand_coord());
        if ($urandom_range(0, 7) == 0)
            now_ns = {$urandom(), 16'($urandom())};
        send_sample(($urandom_range(0, 3) == 0) ? plfd_pkg::MODE_LATER : plfd_pkg::MODE_FIRST,
                    now_ns, rand_ratio());
        n = $urandom_range(2, 6);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 11) == 0) begin
                send_sample(MODE_NONE, 48'($urandom()), 17'($urandom()));
            end else begin
                if ($urandom_range(0, 11) == 0)
                    now_ns = now_ns - $urandom_range(1, 5000);
                else
                    now_ns = now_ns + rand_step();
                send_sample(plfd_pkg::MODE_LATER, now_ns, rand_ratio());
            end
        end
    endtask

    initial begin
        logic [19:0] settings[4];
        int          idle_s[4];
        int          idle_r[4];
        sb = new();
        sb.clear();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        items_sent = 0;
        now_ns     = 48'd5000;
        aresetn    = 0;
        cfg_we     = 0;
        cfg_wdata  = '0;
        s_tvalid   = 0;
        s_tdata    = '0;
        s_tuser    = '0;
        m_tready   = 0;
        repeat (5) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // directed: later-mode sample before any history, at time zero
        send_sample(plfd_pkg::MODE_LATER, 48'd0, 17'd0);
        send_load(0, 3'd0, 32'h8000_0000);
        send_load(1, 3'd0, 32'h7FFF_FFFF);
        send_load(0, 3'd5, 32'h7FFF_FFFF);
        send_load(1, 3'd5, 32'h8000_0000);
        send_load(1, 3'd2, 32'h0001_0000);
        send_load(1, 3'd7, 32'hFFFF_FFFF);       // axis out of range, ignored
        send_load(1, 3'd6, 32'h1234_5678);       // axis out of range, ignored
        send_sample(plfd_pkg::MODE_FIRST, 48'd1000, 17'd0);
        send_sample(plfd_pkg::MODE_LATER, 48'd2000, 17'd65536);   // full swing, huge rate
        send_sample(plfd_pkg::MODE_LATER, 48'd2000, 17'd32768);   // zero step
        send_sample(plfd_pkg::MODE_LATER, 48'd2999, 17'd32769);   // below min_dt
        send_sample(plfd_pkg::MODE_LATER, 48'd1500, 17'd1);       // backward
        send_sample(MODE_NONE, 48'hFFFF_FFFF_FFFF, 17'h1FFFF);
        send_sample(plfd_pkg::MODE_LATER, 48'd2000000, 17'h1FFFF); // extrapolation
        send_sample(plfd_pkg::MODE_LATER, 48'd1002000000, 17'd65535);
        send_sample(plfd_pkg::MODE_LATER, 48'hFFFF_FFFF_FFFF, 17'd100);
        send_sample(plfd_pkg::MODE_FIRST, 48'hFFFF_FFFF_FFFF, 17'd40000);
        wait_idle();

        settings = '{20'd0, 20'hFFFFF, 20'($urandom_range(1, 100000)),
                     plfd_pkg::MIN_DT_RESET};
        idle_s   = '{0, 74, 0, 30};
        idle_r   = '{0, 0, 74, 30};
        for (int p = 0; p < 4; p++) begin
            write_min_dt(settings[p]);
            send_idle_pct  = idle_s[p];
            recv_stall_pct = idle_r[p];
            while (items_sent < 18 + (p + 1) * 52) begin
                run_trajectory();
                // stretch with no idling inside a busy phase
                if ($urandom_range(0, 3) == 0) begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end else begin
                    send_idle_pct  = idle_s[p];
                    recv_stall_pct = idle_r[p];
                end
            end
            wait_idle();
        end

        $display("covered %0d items, %0d samples (%0d with zero derivatives), %0d results",
                 items_sent, sb.samples_seen, sb.skipped_seen, sb.results_seen);
        $display("min_dt settings: reset value, 0, max and a random value");
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule
